// ===== src/sm83_pkg.sv =====
// Shared types and constants for the SM83 ALU and flag unit.
// Holds the operation codes, flag bit positions and the request/response structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sm83_pkg;

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_ADC   = 5'd1,
        OP_SUB   = 5'd2,
        OP_SBC   = 5'd3,
        OP_AND   = 5'd4,
        OP_XOR   = 5'd5,
        OP_OR    = 5'd6,
        OP_CP    = 5'd7,
        OP_INC   = 5'd8,
        OP_DEC   = 5'd9,
        OP_RLCA  = 5'd10,
        OP_RRCA  = 5'd11,
        OP_RLA   = 5'd12,
        OP_RRA   = 5'd13,
        OP_DAA   = 5'd14,
        OP_CPL   = 5'd15,
        OP_SCF   = 5'd16,
        OP_CCF   = 5'd17,
        OP_ADD16 = 5'd18,
        OP_ADDSP = 5'd19,
        OP_RLC   = 5'd20,
        OP_RRC   = 5'd21,
        OP_RL    = 5'd22,
        OP_RR    = 5'd23,
        OP_SLA   = 5'd24,
        OP_SRA   = 5'd25,
        OP_SWAP  = 5'd26,
        OP_SRL   = 5'd27,
        OP_BIT   = 5'd28,
        OP_RES   = 5'd29,
        OP_SET   = 5'd30
    } alu_op_t;

    // Flag bit positions within the 4-bit flag word.
    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    // Decimal adjust constants.
    localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
    localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
    localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
    localparam logic [3:0] DAA_LO_LIMIT = 4'h9;

    typedef struct packed {
        logic [4:0]  req_type;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic [2:0]  bit_index;
        logic [3:0]  flags_in;
    } alu_req_t;

    typedef struct packed {
        logic [15:0] result;
        logic [3:0]  flags_out;
    } alu_rsp_t;

endpackage

`default_nettype wire

// ===== src/sm83_ifs.sv =====
// Valid/ready channel interfaces for the SM83 ALU request and response streams.
// Self-contained; the payload fields mirror the request and response structs.
`timescale 1ns / 1ps
`default_nettype none

interface sm83_req_if;
    logic        valid;
    logic        ready;
    logic [4:0]  req_type;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic [3:0]  flags_in;

    modport source (
        output valid, req_type, operand_a, operand_b, bit_index, flags_in,
        input  ready
    );
    modport sink (
        input  valid, req_type, operand_a, operand_b, bit_index, flags_in,
        output ready
    );
endinterface

interface sm83_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] result;
    logic [3:0]  flags_out;

    modport source (
        output valid, result, flags_out,
        input  ready
    );
    modport sink (
        input  valid, result, flags_out,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/sm83_alu_core.sv =====
// Combinational datapath of the SM83 ALU: computes result and new flags for one request.
// Depends on sm83_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sm83_alu_core (
    input  sm83_pkg::alu_req_t req,
    output sm83_pkg::alu_rsp_t rsp
);
    import sm83_pkg::*;

    alu_op_t     op;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [3:0]  f;
    logic        cin;
    logic [7:0]  bm;

    logic        add_c;
    logic [8:0]  add_sum;
    logic [4:0]  add_nib;
    logic        sub_c;
    logic [8:0]  sub_dif;
    logic [4:0]  sub_nib;

    logic        daa_c;
    logic        daa_lo;
    logic [7:0]  daa_adj;
    logic [7:0]  daa_res;

    logic [16:0] w_sum;
    logic [12:0] w_low;
    logic [15:0] sp_sum;
    logic [8:0]  sp_byte;
    logic [4:0]  sp_nib;

    logic [7:0]  res8;

    assign op  = alu_op_t'(req.req_type);
    assign a   = req.operand_a[7:0];
    assign b   = req.operand_b[7:0];
    assign f   = req.flags_in;
    assign cin = f[FLAG_C];
    assign bm  = 8'h01 << req.bit_index;

    // Add and subtract each take the carry in only for their carry variants.
    assign add_c   = (op == OP_ADC) & cin;
    assign add_sum = {1'b0, a} + {1'b0, b} + {8'h00, add_c};
    assign add_nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, add_c};
    assign sub_c   = (op == OP_SBC) & cin;
    assign sub_dif = {1'b0, a} - {1'b0, b} - {8'h00, sub_c};
    assign sub_nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, sub_c};

    // Decimal adjust: the correction byte is added after an addition and
    // subtracted after a subtraction.
    assign daa_c   = f[FLAG_N] ? cin : (cin | (a > DAA_HI_LIMIT));
    assign daa_lo  = f[FLAG_N] ? f[FLAG_H] : (f[FLAG_H] | (a[3:0] > DAA_LO_LIMIT));
    assign daa_adj = (daa_c ? DAA_HI_ADJ : 8'h00) | (daa_lo ? DAA_LO_ADJ : 8'h00);
    assign daa_res = f[FLAG_N] ? (a - daa_adj) : (a + daa_adj);

    assign w_sum   = {1'b0, req.operand_a} + {1'b0, req.operand_b};
    assign w_low   = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};
    assign sp_sum  = req.operand_a + {{8{b[7]}}, b};
    assign sp_byte = {1'b0, req.operand_a[7:0]} + {1'b0, b};
    assign sp_nib  = {1'b0, req.operand_a[3:0]} + {1'b0, b[3:0]};

    always_comb
    begin
        res8          = 8'h00;
        rsp.result    = 16'h0000;
        rsp.flags_out = f;
        case (op)
            OP_ADD, OP_ADC:
            begin
                res8          = add_sum[7:0];
                rsp.result    = {8'h00, res8};
                rsp.flags_out = {res8 == 8'h00, 1'b0, add_nib[4], add_sum[8]};
            end
            OP_SUB, OP_SBC, OP_CP:
            begin
                res8          = sub_dif[7:0];
                rsp.result    = (op == OP_CP) ? req.operand_a : {8'h00, res8};
                rsp.flags_out = {res8 == 8'h00, 1'b1, sub_nib[4], sub_dif[8]};
            end
            OP_AND:
            begin
                res8          = a & b;
                rsp.result    = {8'h00, res8};
                rsp.flags_out = {res8 == 8'h00, 1'b0, 1'b1, 1'b0};
            end
            OP_XOR:
            begin
                res8          = a ^ b;
                rsp.result    = {8'h00, res8};
                rsp.flags_out = {res8 == 8'h00, 3'b000};
            end
            OP_OR:
            begin
                res8          = a | b;
                rsp.result    = {8'h00, res8};
                rsp.flags_out = {res8 == 8'h00, 3'b000};
            end
            OP_INC:
            begin
                res8          = a + 8'h01;
                rsp.result    = {8'h00, res8};
                rsp.flags_out = {res8 == 8'h00, 1'b0, a[3:0] == 4'hF, cin};
            end
            OP_DEC:
            begin
                res8          = a - 8'h01;
                rsp.result    = {8'h00, res8};
                rsp.flags_out = {res8 == 8'h00, 1'b1, a[3:0] == 4'h0, cin};
            end
            OP_RLCA, OP_RLC:
            begin
                res8          = {a[6:0], a[7]};
                rsp.result    = {8'h00, res8};
                rsp.flags_out = {(op == OP_RLC) & (res8 == 8'h00), 2'b00, a[7]};
            end
            OP_RRCA, OP_RRC:
            begin
                res8          = {a[0], a[7:1]};
                rsp.result    = {8'h00, res8};
                rsp.flags_out = {(op == OP_RRC) & (res8 == 8'h00), 2'b00, a[0]};
            end
            OP_RLA, OP_RL:
            begin
                res8          = {a[6:0], cin};
                rsp.result    = {8'h00, res8};
                rsp.flags_out = {(op == OP_RL) & (res8 == 8'h00), 2'b00, a[7]};
            end
            OP_RRA, OP_RR:
            begin
                res8          = {cin, a[7:1]};
                rsp.result    = {8'h00, res8};
                rsp.flags_out = {(op == OP_RR) & (res8 == 8'h00), 2'b00, a[0]};
            end
            OP_DAA:
            begin
                res8          = daa_res;
                rsp.result    = {8'h00, res8};
                rsp.flags_out = {res8 == 8'h00, f[FLAG_N], 1'b0, daa_c};
            end
            OP_CPL:
            begin
                res8          = ~a;
                rsp.result    = {8'h00, res8};
                rsp.flags_out = {f[FLAG_Z], 1'b1, 1'b1, cin};
            end
            OP_SCF:
            begin
                rsp.result    = req.operand_a;
                rsp.flags_out = {f[FLAG_Z], 2'b00, 1'b1};
            end
            OP_CCF:
            begin
                rsp.result    = req.operand_a;
                rsp.flags_out = {f[FLAG_Z], 2'b00, ~cin};
            end
            OP_ADD16:
            begin
                rsp.result    = w_sum[15:0];
                rsp.flags_out = {f[FLAG_Z], 1'b0, w_low[12], w_sum[16]};
            end
            OP_ADDSP:
            begin
                // Flags come from the unsigned low-byte sum, not the 16-bit one.
                rsp.result    = sp_sum;
                rsp.flags_out = {2'b00, sp_nib[4], sp_byte[8]};
            end
            OP_SLA:
            begin
                res8          = {a[6:0], 1'b0};
                rsp.result    = {8'h00, res8};
                rsp.flags_out = {res8 == 8'h00, 2'b00, a[7]};
            end
            OP_SRA:
            begin
                res8          = {a[7], a[7:1]};
                rsp.result    = {8'h00, res8};
                rsp.flags_out = {res8 == 8'h00, 2'b00, a[0]};
            end
            OP_SWAP:
            begin
                res8          = {a[3:0], a[7:4]};
                rsp.result    = {8'h00, res8};
                rsp.flags_out = {res8 == 8'h00, 3'b000};
            end
            OP_SRL:
            begin
                res8          = {1'b0, a[7:1]};
                rsp.result    = {8'h00, res8};
                rsp.flags_out = {res8 == 8'h00, 2'b00, a[0]};
            end
            OP_BIT:
            begin
                rsp.result    = req.operand_a;
                rsp.flags_out = {(a & bm) == 8'h00, 1'b0, 1'b1, cin};
            end
            OP_RES:
            begin
                res8          = a & ~bm;
                rsp.result    = {8'h00, res8};
            end
            OP_SET:
            begin
                res8          = a | bm;
                rsp.result    = {8'h00, res8};
            end
            default:
            begin
                // The unused code returns zero and leaves the flags alone.
                res8          = 8'h00;
                rsp.result    = 16'h0000;
                rsp.flags_out = f;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/sm83_alu_with_flags.sv =====
// Top level of the SM83 ALU and flag unit: input register, datapath, result register.
// Depends on sm83_pkg, sm83_req_if, sm83_rsp_if and sm83_alu_core.
`timescale 1ns / 1ps
`default_nettype none

// The block accepts one transaction per clock cycle unless the request side
// stalls. A request is captured in the input register, the ALU datapath
// works on it in the following cycle, and the result register holds the
// response until it is taken. The input register hands on its request only
// when the result register is free, but when empty it accepts a new request
// while a finished result still waits; the request side stalls only when
// both registers are full and the response is not taken.
// There is no configuration and no internal state beyond the two registers.
module sm83_alu_with_flags (
    input  wire logic   clk,
    input  wire logic   rst_n,
    sm83_req_if.sink    req,
    sm83_rsp_if.source  rsp
);
    import sm83_pkg::*;

    logic     s1_valid_reg;
    logic     s1_valid_next;
    alu_req_t s1_req_reg;
    logic     s2_valid_reg;
    logic     s2_valid_next;
    alu_rsp_t s2_rsp_reg;
    alu_rsp_t core_rsp;
    logic     s1_free;
    logic     s2_free;
    logic     s1_load;
    logic     s2_load;

    assign s2_free = ~s2_valid_reg | rsp.ready;
    assign s1_free = ~s1_valid_reg | s2_free;
    assign s1_load = req.valid & s1_free;
    assign s2_load = s1_valid_reg & s2_free;

    assign req.ready = s1_free;

    assign s1_valid_next = s1_free ? req.valid : s1_valid_reg;
    assign s2_valid_next = s2_free ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_req_reg.req_type  <= req.req_type;
            s1_req_reg.operand_a <= req.operand_a;
            s1_req_reg.operand_b <= req.operand_b;
            s1_req_reg.bit_index <= req.bit_index;
            s1_req_reg.flags_in  <= req.flags_in;
        end
        if (s2_load)
        begin
            s2_rsp_reg <= core_rsp;
        end
    end

    sm83_alu_core u_core (
        .req (s1_req_reg),
        .rsp (core_rsp)
    );

    assign rsp.valid     = s2_valid_reg;
    assign rsp.result    = s2_rsp_reg.result;
    assign rsp.flags_out = s2_rsp_reg.flags_out;

`ifndef ASSERT_OFF
    // The request side only stalls when both registers hold a transaction.
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (s1_valid_reg && s2_valid_reg))
        else $error("request stalled while a register stage was free");

    // An accepted request always lands in the input register.
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> s1_valid_reg)
        else $error("accepted request was lost from the input register");

    // A held request in the input register keeps its payload while blocked.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_free) |=> (s1_valid_reg && $stable(s1_req_reg)))
        else $error("input register changed while the result register was blocked");

    // The result register captures the datapath output of the previous cycle.
    a_s2_capture: assert property (@(posedge clk) disable iff (!rst_n)
        s2_load |=> (s2_valid_reg && (s2_rsp_reg == $past(core_rsp))))
        else $error("result register did not capture the datapath output");
`endif

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the SM83 ALU and flag unit (sm83_alu_with_flags).
// Drives requests and checks responses against an in-bench ALU predictor.
// Depends on sm83_pkg, sm83_req_if, sm83_rsp_if and the RTL top level.
`timescale 1ns / 1ps

module tb;

    import sm83_pkg::*;

    // Code 31 is not an operation; the block returns zero and keeps the flags.
    localparam logic [4:0] OP_UNUSED = 5'd31;

    localparam int unsigned IDLE_PERCENT = 14;
    localparam int unsigned CALM_START   = 600;
    localparam int unsigned CALM_END     = 1400;
    localparam int unsigned RANDOM_ITEMS = 1600;

    logic clk;
    logic rst_n;

    sm83_req_if req_ch ();
    sm83_rsp_if rsp_ch ();

    sm83_alu_with_flags u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    alu_req_t    pending_reqs[$];
    alu_rsp_t    alu_predictions[$];
    alu_rsp_t    oldest_prediction;
    alu_req_t    next_req;
    alu_req_t    taken_req;
    int unsigned cycle_count;
    int unsigned reqs_accepted = 0;
    int unsigned rsps_checked  = 0;
    int unsigned fail_count    = 0;
    logic [31:0] ops_seen      = 32'h0;

    function automatic logic [3:0] pack_flags(logic z, logic n, logic h, logic c);
        logic [3:0] f;
        f         = 4'h0;
        f[FLAG_Z] = z;
        f[FLAG_N] = n;
        f[FLAG_H] = h;
        f[FLAG_C] = c;
        return f;
    endfunction

    function automatic alu_rsp_t predict_alu(alu_req_t r);
        alu_rsp_t    p;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  t8;
        logic [7:0]  mask;
        logic [8:0]  sum9;
        logic [16:0] sum17;
        logic        cin;
        logic        cy;
        a           = r.operand_a[7:0];
        b           = r.operand_b[7:0];
        cin         = r.flags_in[FLAG_C];
        mask        = 8'd1 << r.bit_index;
        p.result    = 16'h0000;
        p.flags_out = r.flags_in;
        case (r.req_type)
            OP_ADD, OP_ADC:
            begin
                cy          = (r.req_type == OP_ADC) ? cin : 1'b0;
                sum9        = {1'b0, a} + {1'b0, b} + {8'd0, cy};
                p.result    = {8'h00, sum9[7:0]};
                p.flags_out = pack_flags(sum9[7:0] == 8'h00, 1'b0,
                    ({1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cy}) > 5'h0F, sum9[8]);
            end
            OP_SUB, OP_SBC, OP_CP:
            begin
                cy          = (r.req_type == OP_SBC) ? cin : 1'b0;
                t8          = a - b - {7'd0, cy};
                p.flags_out = pack_flags(t8 == 8'h00, 1'b1,
                    {1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'd0, cy}),
                    {1'b0, a} < ({1'b0, b} + {8'd0, cy}));
                p.result    = (r.req_type == OP_CP) ? r.operand_a : {8'h00, t8};
            end
            OP_AND:
            begin
                t8          = a & b;
                p.result    = {8'h00, t8};
                p.flags_out = pack_flags(t8 == 8'h00, 1'b0, 1'b1, 1'b0);
            end
            OP_XOR, OP_OR:
            begin
                t8          = (r.req_type == OP_XOR) ? (a ^ b) : (a | b);
                p.result    = {8'h00, t8};
                p.flags_out = pack_flags(t8 == 8'h00, 1'b0, 1'b0, 1'b0);
            end
            OP_INC:
            begin
                t8          = a + 8'd1;
                p.result    = {8'h00, t8};
                p.flags_out = pack_flags(t8 == 8'h00, 1'b0, a[3:0] == 4'hF, cin);
            end
            OP_DEC:
            begin
                t8          = a - 8'd1;
                p.result    = {8'h00, t8};
                p.flags_out = pack_flags(t8 == 8'h00, 1'b1, a[3:0] == 4'h0, cin);
            end
            // The accumulator rotates always clear Z; the prefixed forms compute it.
            OP_RLCA, OP_RLC:
            begin
                t8          = {a[6:0], a[7]};
                p.result    = {8'h00, t8};
                p.flags_out = pack_flags(r.req_type == OP_RLC && t8 == 8'h00,
                    1'b0, 1'b0, a[7]);
            end
            OP_RRCA, OP_RRC:
            begin
                t8          = {a[0], a[7:1]};
                p.result    = {8'h00, t8};
                p.flags_out = pack_flags(r.req_type == OP_RRC && t8 == 8'h00,
                    1'b0, 1'b0, a[0]);
            end
            OP_RLA, OP_RL:
            begin
                t8          = {a[6:0], cin};
                p.result    = {8'h00, t8};
                p.flags_out = pack_flags(r.req_type == OP_RL && t8 == 8'h00,
                    1'b0, 1'b0, a[7]);
            end
            OP_RRA, OP_RR:
            begin
                t8          = {cin, a[7:1]};
                p.result    = {8'h00, t8};
                p.flags_out = pack_flags(r.req_type == OP_RR && t8 == 8'h00,
                    1'b0, 1'b0, a[0]);
            end
            OP_DAA:
            begin
                t8 = a;
                cy = cin;
                if (!r.flags_in[FLAG_N])
                begin
                    if (cy || a > DAA_HI_LIMIT)
                    begin
                        t8 = t8 + DAA_HI_ADJ;
                        cy = 1'b1;
                    end
                    if (r.flags_in[FLAG_H] || a[3:0] > DAA_LO_LIMIT)
                        t8 = t8 + DAA_LO_ADJ;
                end
                else
                begin
                    if (r.flags_in[FLAG_H])
                        t8 = t8 - DAA_LO_ADJ;
                    if (cy)
                        t8 = t8 - DAA_HI_ADJ;
                end
                p.result    = {8'h00, t8};
                p.flags_out = pack_flags(t8 == 8'h00, r.flags_in[FLAG_N], 1'b0, cy);
            end
            OP_CPL:
            begin
                p.result    = {8'h00, ~a};
                p.flags_out = r.flags_in | pack_flags(1'b0, 1'b1, 1'b1, 1'b0);
            end
            OP_SCF:
            begin
                p.result    = r.operand_a;
                p.flags_out = pack_flags(r.flags_in[FLAG_Z], 1'b0, 1'b0, 1'b1);
            end
            OP_CCF:
            begin
                p.result    = r.operand_a;
                p.flags_out = pack_flags(r.flags_in[FLAG_Z], 1'b0, 1'b0, ~cin);
            end
            OP_ADD16:
            begin
                sum17       = {1'b0, r.operand_a} + {1'b0, r.operand_b};
                p.result    = sum17[15:0];
                p.flags_out = pack_flags(r.flags_in[FLAG_Z], 1'b0,
                    ({1'b0, r.operand_a[11:0]} + {1'b0, r.operand_b[11:0]}) > 13'h0FFF,
                    sum17[16]);
            end
            OP_ADDSP:
            begin
                // Flags come from the unsigned low-byte add, the sum from the
                // sign-extended offset.
                p.result    = r.operand_a + {{8{b[7]}}, b};
                p.flags_out = pack_flags(1'b0, 1'b0,
                    ({1'b0, r.operand_a[3:0]} + {1'b0, b[3:0]}) > 5'h0F,
                    ({1'b0, r.operand_a[7:0]} + {1'b0, b}) > 9'h0FF);
            end
            OP_SLA:
            begin
                t8          = {a[6:0], 1'b0};
                p.result    = {8'h00, t8};
                p.flags_out = pack_flags(t8 == 8'h00, 1'b0, 1'b0, a[7]);
            end
            OP_SRA:
            begin
                t8          = {a[7], a[7:1]};
                p.result    = {8'h00, t8};
                p.flags_out = pack_flags(t8 == 8'h00, 1'b0, 1'b0, a[0]);
            end
            OP_SWAP:
            begin
                t8          = {a[3:0], a[7:4]};
                p.result    = {8'h00, t8};
                p.flags_out = pack_flags(t8 == 8'h00, 1'b0, 1'b0, 1'b0);
            end
            OP_SRL:
            begin
                t8          = {1'b0, a[7:1]};
                p.result    = {8'h00, t8};
                p.flags_out = pack_flags(t8 == 8'h00, 1'b0, 1'b0, a[0]);
            end
            OP_BIT:
            begin
                p.result    = r.operand_a;
                p.flags_out = pack_flags((a & mask) == 8'h00, 1'b0, 1'b1, cin);
            end
            OP_RES:
                p.result = {8'h00, a & ~mask};
            OP_SET:
                p.result = {8'h00, a | mask};
            default:
                p.result = 16'h0000;
        endcase
        return p;
    endfunction

    function automatic alu_req_t make_req(logic [4:0] op, logic [15:0] a, logic [15:0] b,
                                          logic [2:0] bi, logic [3:0] f);
        alu_req_t r;
        r.req_type  = op;
        r.operand_a = a;
        r.operand_b = b;
        r.bit_index = bi;
        r.flags_in  = f;
        return r;
    endfunction

    // Biased toward bytes that sit on carry, half-carry and BCD boundaries.
    function automatic logic [15:0] random_operand();
        logic [15:0] w;
        w = 16'($urandom);
        case ($urandom_range(7))
            0: w[7:0] = 8'h00;
            1: w[7:0] = 8'hFF;
            2: w[3:0] = 4'hF;
            3:
            begin
                w[7:4] = 4'($urandom_range(9));
                w[3:0] = 4'($urandom_range(9));
            end
            4: w[11:0] = 12'hFFF;
            default: ;
        endcase
        return w;
    endfunction

    function automatic alu_req_t random_request();
        alu_req_t r;
        r.req_type  = 5'($urandom_range(31));
        r.operand_a = random_operand();
        r.operand_b = random_operand();
        r.bit_index = 3'($urandom_range(7));
        r.flags_in  = 4'($urandom_range(15));
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || req_ch.valid || alu_predictions.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cycle_count <= 0;
        else
            cycle_count <= cycle_count + 1;
    end

    // Request driver: record each accepted transaction's prediction, then
    // offer the next pending request unless this cycle idles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid     <= 1'b0;
            req_ch.req_type  <= 5'd0;
            req_ch.operand_a <= 16'h0000;
            req_ch.operand_b <= 16'h0000;
            req_ch.bit_index <= 3'd0;
            req_ch.flags_in  <= 4'h0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                taken_req = make_req(req_ch.req_type, req_ch.operand_a, req_ch.operand_b,
                                     req_ch.bit_index, req_ch.flags_in);
                alu_predictions.push_back(predict_alu(taken_req));
                ops_seen[taken_req.req_type] = 1'b1;
                reqs_accepted++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_reqs.size() != 0 &&
                    ((cycle_count >= CALM_START && cycle_count < CALM_END) ||
                     $urandom_range(99) >= IDLE_PERCENT))
                begin
                    next_req = pending_reqs.pop_front();
                    req_ch.valid     <= 1'b1;
                    req_ch.req_type  <= next_req.req_type;
                    req_ch.operand_a <= next_req.operand_a;
                    req_ch.operand_b <= next_req.operand_b;
                    req_ch.bit_index <= next_req.bit_index;
                    req_ch.flags_in  <= next_req.flags_in;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // Response monitor: compare each accepted transaction with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                rsps_checked++;
                if (alu_predictions.size() == 0)
                begin
                    $error("unexpected response: result %h, flags_out %h",
                           rsp_ch.result, rsp_ch.flags_out);
                    fail_count++;
                end
                else
                begin
                    oldest_prediction = alu_predictions.pop_front();
                    if (rsp_ch.result !== oldest_prediction.result)
                    begin
                        $error("result mismatch: expected %h, actual %h",
                               oldest_prediction.result, rsp_ch.result);
                        fail_count++;
                    end
                    if (rsp_ch.flags_out !== oldest_prediction.flags_out)
                    begin
                        $error("flags_out mismatch: expected %h, actual %h",
                               oldest_prediction.flags_out, rsp_ch.flags_out);
                        fail_count++;
                    end
                end
            end
            rsp_ch.ready <= (cycle_count >= CALM_START && cycle_count < CALM_END) ||
                            ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    initial
    begin
        int guard;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Every code once, the unused one included, with all-zero and all-one operands.
        for (int k = 0; k < 32; k++)
            pending_reqs.push_back(make_req(k[4:0], {16{k[0]}}, {16{k[1]}},
                                            k[2:0], ~k[3:0]));
        pending_reqs.push_back(make_req(OP_ADD, 16'h00FF, 16'h0001, 3'd0, 4'h0));
        pending_reqs.push_back(make_req(OP_DAA, 16'h009A, 16'h0000, 3'd0, 4'h0));
        pending_reqs.push_back(make_req(OP_DAA, 16'h0000, 16'h0000, 3'd0, 4'h7));
        pending_reqs.push_back(make_req(OP_ADD16, 16'h0FFF, 16'h0001, 3'd0, 4'h8));
        pending_reqs.push_back(make_req(OP_ADDSP, 16'h0000, 16'h0080, 3'd0, 4'hF));
        pending_reqs.push_back(make_req(OP_BIT, 16'h0080, 16'h0000, 3'd7, 4'h0));
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS / 2; i++)
            pending_reqs.push_back(random_request());
        // Let the pipeline empty completely before the second half.
        wait_drained();
        for (int i = 0; i < RANDOM_ITEMS / 2; i++)
            pending_reqs.push_back(random_request());

        guard = 0;
        while ((pending_reqs.size() != 0 || req_ch.valid || alu_predictions.size() != 0) &&
               guard < 20000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (8) @(negedge clk);
        if (pending_reqs.size() != 0 || req_ch.valid)
        begin
            $error("%0d requests were never accepted", pending_reqs.size());
            fail_count++;
        end
        if (alu_predictions.size() != 0)
        begin
            $error("%0d expected responses never arrived", alu_predictions.size());
            fail_count++;
        end

        $display("Covered %0d requests across %0d operation codes, %0d responses checked.",
                 reqs_accepted, $countones(ops_seen), rsps_checked);
        $display("Mismatches and protocol errors: %0d.", fail_count);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
